// ----- design/double_ended_queue_defines.svh -----
// Assertion macros used by the checker file.
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define DEQ_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("deque check failed");

// Next-cycle implication.
`define DEQ_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("deque check failed");

`endif

// ----- design/deq_pkg.sv -----
package deq_pkg;

	localparam int unsigned DATA_W = 32;

	localparam logic [2:0] FUNC_PUSH_FRONT = 3'd0;
	localparam logic [2:0] FUNC_PUSH_BACK  = 3'd1;
	localparam logic [2:0] FUNC_POP_FRONT  = 3'd2;
	localparam logic [2:0] FUNC_POP_BACK   = 3'd3;
	localparam logic [2:0] FUNC_NONE       = 3'd4;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_SHR,
		CELL_SHL,
		CELL_WR
	} cell_op_t;

	typedef struct packed {
		cell_op_t                 op;
		logic signed [DATA_W-1:0] din;
	} chain_cmd_t;

endpackage

// ----- design/deq_cell.sv -----
module deq_cell (
	input  logic                              clk,
	input  deq_pkg::cell_op_t                 op,
	input  logic                              sel,
	input  logic signed [deq_pkg::DATA_W-1:0] din,
	input  logic signed [deq_pkg::DATA_W-1:0] from_left,
	input  logic signed [deq_pkg::DATA_W-1:0] from_right,
	output logic signed [deq_pkg::DATA_W-1:0] val
);
	import deq_pkg::*;

	logic signed [DATA_W-1:0] val_q;

	always_ff @(posedge clk) begin
		unique case (op)
			CELL_SHR: val_q <= from_left;
			CELL_SHL: val_q <= from_right;
			CELL_WR: begin
				if (sel) begin
					val_q <= din;
				end
			end
			default: val_q <= val_q;
		endcase
	end

	assign val = val_q;

endmodule

// ----- design/deq_chain.sv -----
module deq_chain #(
	parameter int unsigned DEPTH = 16,
	localparam int unsigned CW = $clog2(DEPTH + 1)
) (
	input  logic                              clk,
	input  deq_pkg::chain_cmd_t               cmd,
	input  logic [CW-1:0]                     count,
	output logic signed [deq_pkg::DATA_W-1:0] head
);
	import deq_pkg::*;

	logic signed [DATA_W-1:0] cell_val [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [DATA_W-1:0] left_v;
		logic signed [DATA_W-1:0] right_v;

		if (i == 0) begin : g_first
			assign left_v = cmd.din;
		end else begin : g_mid_l
			assign left_v = cell_val[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_v = cell_val[i];
		end else begin : g_mid_r
			assign right_v = cell_val[i+1];
		end

		deq_cell u_cell (
			.clk        (clk),
			.op         (cmd.op),
			.sel        (count == CW'(i)),
			.din        (cmd.din),
			.from_left  (left_v),
			.from_right (right_v),
			.val        (cell_val[i])
		);
	end

	assign head = cell_val[0];

endmodule

// ----- design/double_ended_queue.sv -----
// Channel  Dir  tdata (low bit up)                                 tuser
// s_*      in   push_value[31:0]                                   func[2:0]
// m_*      out  front_value, back_value, is_empty, is_full,       -
//               occupancy, push_dropped, pop_ignored, zero pad
//
// One transaction per cycle while m_* is not stalled; its result shows on m_* the cycle after acceptance.
// Two chains of DEPTH cells hold the queue in order and reversed, so front and back
// sit in the first cell of each chain; every op is one shift or one indexed write.
// s_tready stays high while the output register is empty or being drained.
// arst_n clears the count and the output valid; cell contents need no reset.
module double_ended_queue #(
	parameter int unsigned DEPTH = 16,
	localparam int unsigned CW = $clog2(DEPTH + 1),
	localparam int unsigned OUT_BITS = 2 * deq_pkg::DATA_W + 4 + CW,
	localparam int unsigned OUT_W = ((OUT_BITS + 7) / 8) * 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [31:0]               s_tdata,  // push_value
	input  logic [2:0]                s_tuser,  // func
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [OUT_W-1:0]          m_tdata   // front, back, empty, full, occupancy, dropped, ignored
);
	import deq_pkg::*;

	logic          out_valid_q;
	logic [CW-1:0] count_q;
	logic          dropped_q;
	logic          ignored_q;
	logic          accept;
	logic          full;
	logic          empty;
	chain_cmd_t    fwd_cmd;
	chain_cmd_t    rev_cmd;
	logic [CW-1:0] count_nxt;
	logic          dropped_nxt;
	logic          ignored_nxt;
	logic signed [DATA_W-1:0] fwd_head;
	logic signed [DATA_W-1:0] rev_head;
	logic signed [DATA_W-1:0] front_v;
	logic signed [DATA_W-1:0] back_v;

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign full     = count_q == CW'(DEPTH);
	assign empty    = count_q == '0;

	always_comb begin
		fwd_cmd.op  = CELL_HOLD;
		fwd_cmd.din = $signed(s_tdata);
		rev_cmd.op  = CELL_HOLD;
		rev_cmd.din = $signed(s_tdata);
		count_nxt   = count_q;
		dropped_nxt = 1'b0;
		ignored_nxt = 1'b0;
		unique case (s_tuser)
			FUNC_PUSH_FRONT: begin
				if (full) begin
					dropped_nxt = 1'b1;
				end else begin
					fwd_cmd.op = CELL_SHR;
					rev_cmd.op = CELL_WR;
					count_nxt  = count_q + 1'b1;
				end
			end
			FUNC_PUSH_BACK: begin
				if (full) begin
					dropped_nxt = 1'b1;
				end else begin
					fwd_cmd.op = CELL_WR;
					rev_cmd.op = CELL_SHR;
					count_nxt  = count_q + 1'b1;
				end
			end
			FUNC_POP_FRONT: begin
				if (empty) begin
					ignored_nxt = 1'b1;
				end else begin
					fwd_cmd.op = CELL_SHL;
					count_nxt  = count_q - 1'b1;
				end
			end
			FUNC_POP_BACK: begin
				if (empty) begin
					ignored_nxt = 1'b1;
				end else begin
					rev_cmd.op = CELL_SHL;
					count_nxt  = count_q - 1'b1;
				end
			end
			default: begin
			end
		endcase
		if (!accept) begin
			fwd_cmd.op = CELL_HOLD;
			rev_cmd.op = CELL_HOLD;
		end
	end

	deq_chain #(.DEPTH(DEPTH)) u_fwd (
		.clk   (clk),
		.cmd   (fwd_cmd),
		.count (count_q),
		.head  (fwd_head)
	);

	deq_chain #(.DEPTH(DEPTH)) u_rev (
		.clk   (clk),
		.cmd   (rev_cmd),
		.count (count_q),
		.head  (rev_head)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			count_q     <= '0;
			dropped_q   <= 1'b0;
			ignored_q   <= 1'b0;
		end else begin
			if (accept) begin
				out_valid_q <= 1'b1;
				count_q     <= count_nxt;
				dropped_q   <= dropped_nxt;
				ignored_q   <= ignored_nxt;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign front_v = empty ? '0 : fwd_head;
	assign back_v  = empty ? '0 : rev_head;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_W'({ignored_q, dropped_q, count_q, full, empty, back_v, front_v});

endmodule

// ----- design/deq_checker.sv -----
`include "double_ended_queue_defines.svh"

module deq_checker #(
	parameter int unsigned DEPTH = 16,
	localparam int unsigned CW = $clog2(DEPTH + 1),
	localparam int unsigned OUT_BITS = 64 + 4 + CW,
	localparam int unsigned OUT_W = ((OUT_BITS + 7) / 8) * 8
) (
	input logic             clk,
	input logic             arst_n,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata
);
	logic [31:0]   front_v;
	logic [31:0]   back_v;
	logic          empty;
	logic          full;
	logic [CW-1:0] occ;
	logic          dropped;
	logic          ignored;

	assign front_v = m_tdata[31:0];
	assign back_v  = m_tdata[63:32];
	assign empty   = m_tdata[64];
	assign full    = m_tdata[65];
	assign occ     = m_tdata[66 +: CW];
	assign dropped = m_tdata[66 + CW];
	assign ignored = m_tdata[67 + CW];

	`DEQ_ASSERT_IMP(a_empty_zero, clk, arst_n, m_tvalid && empty, front_v == '0 && back_v == '0)
	`DEQ_ASSERT_IMP(a_empty_occ, clk, arst_n, m_tvalid, empty == (occ == '0))
	`DEQ_ASSERT_IMP(a_full_occ, clk, arst_n, m_tvalid, full == (occ == CW'(DEPTH)))
	`DEQ_ASSERT_IMP(a_event_flags, clk, arst_n, m_tvalid, (!dropped || full) && (!ignored || empty))
	`DEQ_ASSERT_NXT(a_stall_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind double_ended_queue deq_checker #(.DEPTH(DEPTH)) u_deq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
